@@ rtl/mmh_pkg.sv @@
// Shared package for the murmur64a hash stream unit.
// Holds the mix constants, sequencer states, multiplier request and response types and helpers.
// No dependencies.
`default_nettype none

package mmh_pkg;

  // Mix multiplier and shift amount
  localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixShift = 47;

  // Bytes in a full data word
  localparam logic [3:0] FullBytes = 4'd8;

  // Config register byte addresses
  localparam logic [1:0] SeedAddr = 2'd0;

  // Partial product steps of the shared multiplier
  localparam logic [1:0] MulStepLo    = 2'd0;
  localparam logic [1:0] MulStepCross = 2'd1;
  localparam logic [1:0] MulStepLast  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DISPATCH,
    ST_MIX1,
    ST_MIX2,
    ST_FOLD,
    ST_FIN,
    ST_OUT
  } mmh_state_e;

  // Request to the shared multiplier: operand times MixMul, modulo 2^64
  typedef struct packed {
    logic        start;
    logic [63:0] opnd;
  } mul_req_t;

  // Response from the shared multiplier
  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // x ^ (x >> 47)
  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    xor_shift = x ^ (x >> MixShift);
  endfunction

  // Keep the low cnt bytes of a word (cnt in 0..8)
  function automatic logic [63:0] tail_bytes(input logic [63:0] w, input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    tail_bytes = w & m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mmh_mul.sv @@
// Shared multiplier: operand times the mix constant, modulo 2^64.
// One 32x32 multiplier used in turn for the low and the two cross partial products.
// Depends on mmh_pkg.
`default_nettype none

module mmh_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mmh_pkg::mul_req_t req_i,
  output mmh_pkg::mul_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] opnd_q, opnd_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Operand select for the current partial product
  always_comb begin
    case (step_q)
      mmh_pkg::MulStepLo: begin
        mul_a = opnd_q[31:0];
        mul_b = mmh_pkg::MixMul[31:0];
      end
      mmh_pkg::MulStepCross: begin
        mul_a = opnd_q[63:32];
        mul_b = mmh_pkg::MixMul[31:0];
      end
      default: begin
        mul_a = opnd_q[31:0];
        mul_b = mmh_pkg::MixMul[63:32];
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Step control and accumulation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    opnd_d = opnd_q;
    acc_d  = acc_q;
    if (busy_q) begin
      if (step_q == mmh_pkg::MulStepLo) begin
        acc_d = prod;
      end else begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
      end
      if (step_q == mmh_pkg::MulStepLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = mmh_pkg::MulStepLo;
      opnd_d = req_i.opnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= mmh_pkg::MulStepLo;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

@@ rtl/mmh_seq.sv @@
// Sequencer and hash state: steps one input word through init, mix, fold and finalize.
// Issues every multiply to the shared multiplier. Depends on mmh_pkg.
`default_nettype none

module mmh_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       seed_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [63:0]       data_word_i,
  input  wire logic [3:0]        byte_count_i,
  input  wire logic [30:0]       key_length_i,
  input  wire logic              last_item_i,
  input  wire logic              slot_free_i,
  output logic                   res_valid_o,
  output logic [63:0]            res_data_o,
  output mmh_pkg::mul_req_t      mul_req_o,
  input  wire mmh_pkg::mul_rsp_t mul_rsp_i
);

  mmh_pkg::mmh_state_e state_q, state_d;
  logic        started_q, started_d;
  logic [63:0] hash_q, hash_d;
  logic [63:0] word_q, word_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [63:0] res_q, res_d;
  logic        accept;

  assign in_stall_o = (state_q != mmh_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == mmh_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmh_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = started_q ? mmh_pkg::ST_DISPATCH : mmh_pkg::ST_INIT;
        end
      end
      mmh_pkg::ST_INIT: begin
        if (mul_rsp_i.done) state_d = mmh_pkg::ST_DISPATCH;
      end
      mmh_pkg::ST_DISPATCH: begin
        if (cnt_q == mmh_pkg::FullBytes) begin
          state_d = mmh_pkg::ST_MIX1;
        end else if (cnt_q != 4'd0) begin
          state_d = mmh_pkg::ST_FOLD;
        end else if (last_q) begin
          state_d = mmh_pkg::ST_FIN;
        end else begin
          state_d = mmh_pkg::ST_IDLE;
        end
      end
      mmh_pkg::ST_MIX1: begin
        if (mul_rsp_i.done) state_d = mmh_pkg::ST_MIX2;
      end
      mmh_pkg::ST_MIX2: begin
        if (mul_rsp_i.done) state_d = mmh_pkg::ST_FOLD;
      end
      mmh_pkg::ST_FOLD: begin
        if (mul_rsp_i.done) state_d = last_q ? mmh_pkg::ST_FIN : mmh_pkg::ST_IDLE;
      end
      mmh_pkg::ST_FIN: begin
        if (mul_rsp_i.done) state_d = mmh_pkg::ST_OUT;
      end
      mmh_pkg::ST_OUT: begin
        if (slot_free_i) state_d = mmh_pkg::ST_IDLE;
      end
      default: state_d = mmh_pkg::ST_IDLE;
    endcase
  end

  // Outputs, multiplier requests and datapath updates
  always_comb begin
    started_d      = started_q;
    hash_d         = hash_q;
    word_d         = word_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    res_d          = res_q;
    res_valid_o    = 1'b0;
    mul_req_o.start = 1'b0;
    mul_req_o.opnd  = hash_q;
    case (state_q)
      mmh_pkg::ST_IDLE: begin
        if (accept) begin
          word_d = data_word_i;
          cnt_d  = (byte_count_i > mmh_pkg::FullBytes) ? mmh_pkg::FullBytes : byte_count_i;
          last_d = last_item_i;
          if (!started_q) begin
            // key length times the mix constant
            mul_req_o.start = 1'b1;
            mul_req_o.opnd  = {33'd0, key_length_i};
          end
        end
      end
      mmh_pkg::ST_INIT: begin
        if (mul_rsp_i.done) hash_d = {32'd0, seed_i} ^ mul_rsp_i.prod;
      end
      mmh_pkg::ST_DISPATCH: begin
        if (cnt_q == mmh_pkg::FullBytes) begin
          mul_req_o.start = 1'b1;
          mul_req_o.opnd  = word_q;
        end else if (cnt_q != 4'd0) begin
          // tail bytes xored in, then multiplied
          mul_req_o.start = 1'b1;
          mul_req_o.opnd  = hash_q ^ mmh_pkg::tail_bytes(word_q, cnt_q);
        end else if (last_q) begin
          mul_req_o.start = 1'b1;
          mul_req_o.opnd  = mmh_pkg::xor_shift(hash_q);
        end else begin
          started_d = 1'b1;
        end
      end
      mmh_pkg::ST_MIX1: begin
        if (mul_rsp_i.done) begin
          mul_req_o.start = 1'b1;
          mul_req_o.opnd  = mmh_pkg::xor_shift(mul_rsp_i.prod);
        end
      end
      mmh_pkg::ST_MIX2: begin
        if (mul_rsp_i.done) begin
          mul_req_o.start = 1'b1;
          mul_req_o.opnd  = hash_q ^ mul_rsp_i.prod;
        end
      end
      mmh_pkg::ST_FOLD: begin
        if (mul_rsp_i.done) begin
          hash_d = mul_rsp_i.prod;
          if (last_q) begin
            mul_req_o.start = 1'b1;
            mul_req_o.opnd  = mmh_pkg::xor_shift(mul_rsp_i.prod);
          end else begin
            started_d = 1'b1;
          end
        end
      end
      mmh_pkg::ST_FIN: begin
        if (mul_rsp_i.done) res_d = mmh_pkg::xor_shift(mul_rsp_i.prod);
      end
      mmh_pkg::ST_OUT: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          started_d   = 1'b0;
          hash_d      = '0;
        end
      end
      default: ;
    endcase
  end

  assign res_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmh_pkg::ST_IDLE;
      started_q <= 1'b0;
      hash_q    <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      hash_q    <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

@@ rtl/murmur64a_hash_stream_unit.sv @@
// Top level of the murmur64a hash stream unit: seed register, APB port and output word register.
// Instantiates mmh_seq and mmh_mul; depends on mmh_pkg.
//
//   chan | dir | handshake               | payload
//   -----+-----+-------------------------+--------------------------------------------------
//   in   | in  | in_valid_i/in_stall_o   | data_word_i, byte_count_i, key_length_i, last_item_i
//   out  | out | out_valid_o/out_stall_i | hash_value_o
//   cfg  | in  | psel/penable, pready    | paddr, pwrite, pwdata, prdata (hash_seed at 0)
//
// Each 64-bit multiply runs on one shared 32x32 multiplier, one partial product after
// another, and the product is handed back from a register. The multiplies a word needs:
// three for a full word, one for a tail, none for an empty word, plus one for a key's
// first word and one for its last; a last word also passes through the output state to
// hand its result over.
// Reset clears the sequencer, running hash and seed. A result waits in the output register
// until taken; the next key's result then holds the sequencer, which stalls the input.
`default_nettype none

module murmur64a_hash_stream_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic [30:0] key_length_i,
  input  wire logic        last_item_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_value_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0]       seed_q, seed_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       hash_q, hash_d;
  logic              slot_free;
  logic              res_valid;
  logic [63:0]       res_data;
  mmh_pkg::mul_req_t mul_req;
  mmh_pkg::mul_rsp_t mul_rsp;

  // Seed register
  assign pready = 1'b1;
  always_comb begin
    seed_d = seed_q;
    if (psel && penable && pwrite && (paddr == mmh_pkg::SeedAddr)) seed_d = pwdata;
  end
  assign prdata = (paddr == mmh_pkg::SeedAddr) ? seed_q : 32'd0;

  // Output word register
  assign slot_free = !out_valid_q || !out_stall_i;
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      hash_d      = res_data;
    end
  end
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  mmh_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .key_length_i (key_length_i),
    .last_item_i  (last_item_i),
    .slot_free_i  (slot_free),
    .res_valid_o  (res_valid),
    .res_data_o   (res_data),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp)
  );

  mmh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule

`default_nettype wire

@@ dv/tb_murmur64a_hash_stream_unit.sv @@
// Self-checking testbench for murmur64a_hash_stream_unit: directed table, then random keys.
// Predicts each finalized hash in SystemVerilog and checks the result words in order.
// Depends on rtl/mmh_pkg.sv and rtl/murmur64a_hash_stream_unit.sv.
`timescale 1ns / 100ps

module tb_murmur64a_hash_stream_unit;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 500;

  // One row of the directed table; want is used only when pinned is set
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic [30:0] len;
    logic        fin;
    logic        pinned;
    logic [63:0] want;
  } stim_row_t;

  localparam stim_row_t DirRows [20] = '{
    // empty key, reset seed: hashes to zero
    '{64'h0, 4'd0, 31'd0, 1'b1, 1'b1, 64'h0},
    // single full words at the data extremes
    '{64'hffff_ffff_ffff_ffff, 4'd8, 31'd8, 1'b1, 1'b0, 64'h0},
    '{64'h0, 4'd8, 31'd8, 1'b1, 1'b0, 64'h0},
    // byte count above eight acts as a full word; max key length
    '{64'h0123_4567_89ab_cdef, 4'd15, 31'h7fff_ffff, 1'b1, 1'b0, 64'h0},
    '{64'hfedc_ba98_7654_3210, 4'd9, 31'd0, 1'b1, 1'b0, 64'h0},
    // tails of one to seven bytes, upper bytes set so masking shows
    '{64'hffff_ffff_ffff_ffff, 4'd1, 31'd1, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd2, 31'd2, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd3, 31'd3, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd4, 31'd4, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd5, 31'd5, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd6, 31'd6, 1'b1, 1'b0, 64'h0},
    '{64'hffff_ffff_ffff_ffff, 4'd7, 31'd7, 1'b1, 1'b0, 64'h0},
    // multi-word key with a partial word in the middle, closed by an empty word
    '{64'ha5a5_a5a5_5a5a_5a5a, 4'd8, 31'd24, 1'b0, 1'b0, 64'h0},
    '{64'hdead_beef_cafe_f00d, 4'd3, 31'd0, 1'b0, 1'b0, 64'h0},
    '{64'h1122_3344_5566_7788, 4'd8, 31'd0, 1'b0, 1'b0, 64'h0},
    '{64'h0, 4'd0, 31'd0, 1'b1, 1'b0, 64'h0},
    // stated length disagrees with the bytes sent
    '{64'h8000_0000_0000_0001, 4'd8, 31'd100, 1'b1, 1'b0, 64'h0},
    // empty first word that does not end the key
    '{64'h5555_5555_5555_5555, 4'd0, 31'd9, 1'b0, 1'b0, 64'h0},
    '{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 31'd0, 1'b1, 1'b0, 64'h0},
    // key left open; the seed changes before it continues
    '{64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 31'd16, 1'b0, 1'b0, 64'h0}
  };

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_word_i  = '0;
  logic [3:0]  byte_count_i = '0;
  logic [30:0] key_length_i = '0;
  logic        last_item_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [63:0] hash_value_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [1:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  murmur64a_hash_stream_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .key_length_i (key_length_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow of the hash state and seed
  logic [31:0] seed_q   = '0;
  logic [63:0] acc_hash = '0;
  logic        key_open = 1'b0;

  logic [63:0] pending_hashes [$];
  int unsigned error_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] mix64(input logic [63:0] k);
    logic [63:0] t;
    t = k * mmh_pkg::MixMul;
    t = t ^ (t >> mmh_pkg::MixShift);
    return t * mmh_pkg::MixMul;
  endfunction

  // Fold one word into the shadow hash; returns 1 with the digest when the key ends
  function automatic bit absorb_word(input logic [63:0] w, input logic [3:0] cnt,
                                     input logic [30:0] len, input logic fin,
                                     output logic [63:0] digest);
    logic [63:0] h;
    logic [63:0] mask;
    logic [3:0]  n;
    n = (cnt > mmh_pkg::FullBytes) ? mmh_pkg::FullBytes : cnt;
    h = key_open ? acc_hash : ({32'd0, seed_q} ^ ({33'd0, len} * mmh_pkg::MixMul));
    if (n == mmh_pkg::FullBytes) begin
      h = (h ^ mix64(w)) * mmh_pkg::MixMul;
    end else if (n != 4'd0) begin
      mask = ~64'd0 >> (8 * (8 - n));
      h = (h ^ (w & mask)) * mmh_pkg::MixMul;
    end
    digest = '0;
    if (fin) begin
      h = h ^ (h >> mmh_pkg::MixShift);
      h = h * mmh_pkg::MixMul;
      h = h ^ (h >> mmh_pkg::MixShift);
      digest   = h;
      acc_hash = '0;
      key_open = 1'b0;
      return 1'b1;
    end
    acc_hash = h;
    key_open = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one word, optionally after a gap, and record its expected hash on acceptance
  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt,
                           input logic [30:0] len, input logic fin);
    logic [63:0] digest;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= w;
    byte_count_i <= cnt;
    key_length_i <= len;
    last_item_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    if (absorb_word(w, cnt, len, fin, digest)) begin
      pending_hashes.push_back(digest);
    end
  endtask

  // APB transfer with setup and access phases; returns prdata from the access cycle
  task automatic apb_xfer(input logic wr, input logic [1:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_seed();
    logic [31:0] rd;
    apb_xfer(1'b0, mmh_pkg::SeedAddr, '0, rd);
    if (rd !== seed_q) begin
      $display("%0t: seed readback mismatch: expected %h actual %h", $time, seed_q, rd);
      error_cnt++;
    end
  endtask

  task automatic write_seed(input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, mmh_pkg::SeedAddr, value, rd);
    seed_q = value;
    @(posedge clk_i);
    check_seed();
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed keys with random content, plus broken sequences and noise
  task automatic hash_random_keys(input int n_items);
    int          sent;
    int          kind;
    int          nfull;
    int          tail;
    int          nb;
    logic [30:0] klen;
    logic        closed;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        if ($urandom_range(9) == 0) begin
          klen  = 31'($urandom);
          nfull = $urandom_range(0, 3);
          tail  = $urandom_range(0, 7);
        end else begin
          klen  = 31'($urandom_range(0, 48));
          nfull = klen / 8;
          tail  = klen % 8;
        end
        closed = 1'b0;
        for (int i = 0; i < nfull; i++) begin
          closed = (tail == 0) && (i == nfull - 1) && ($urandom_range(1) == 1);
          send_word(rand_word(), mmh_pkg::FullBytes, (i == 0) ? klen : 31'($urandom), closed);
          sent++;
        end
        if (!closed) begin
          send_word(rand_word(), 4'(tail), (nfull == 0) ? klen : 31'($urandom), 1'b1);
          sent++;
        end
      end else if (kind < 90) begin
        // arbitrary byte counts mid-key
        nb = $urandom_range(1, 4);
        for (int j = 0; j < nb; j++) begin
          send_word(rand_word(), 4'($urandom_range(0, 15)), 31'($urandom),
                    (j == nb - 1) && ($urandom_range(1) == 1));
          sent++;
        end
      end else begin
        send_word(rand_word(), 4'($urandom), 31'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Result side: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted hash word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash word: expected none actual %h", $time, hash_value_o);
        error_cnt++;
      end else begin
        if (hash_value_o !== pending_hashes[0]) begin
          $display("%0t: hash mismatch: expected %h actual %h", $time, pending_hashes[0],
                   hash_value_o);
          error_cnt++;
        end
        void'(pending_hashes.pop_front());
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("murmur64a_hash_stream_unit verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_seed();

    // directed table with reset seed
    send_idle_pct  <= 18;
    recv_stall_pct <= 62;
    foreach (DirRows[r]) begin
      send_word(DirRows[r].data, DirRows[r].cnt, DirRows[r].len, DirRows[r].fin);
      if (DirRows[r].pinned) begin
        pending_hashes[pending_hashes.size() - 1] = DirRows[r].want;
      end
    end
    settle();

    // the open key continues under the new seed
    write_seed(32'hffff_ffff);
    hash_random_keys(PhaseItems);
    settle();

    send_idle_pct  <= 62;
    recv_stall_pct <= 18;
    write_seed($urandom);
    hash_random_keys(PhaseItems);
    settle();

    // no idling; long receiver hold-off fills the block
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    write_seed(32'h0);
    hold_req <= hold_req + 1;
    hash_random_keys(PhaseItems);
    settle();

    if (pending_hashes.size() != 0) begin
      $display("%0t: hash words missing: expected %0d more actual 0", $time,
               pending_hashes.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("murmur64a_hash_stream_unit verification clean");
    end else begin
      $display("murmur64a_hash_stream_unit verification failed");
    end
    $finish;
  end

endmodule
